>>> rtl/core/sha256_stream_hasher_core_assert.svh
// Assertion macros for the SHA-256 stream hasher core
`ifndef SHA256_STREAM_HASHER_CORE_ASSERT_SVH
`define SHA256_STREAM_HASHER_CORE_ASSERT_SVH
// Implication checked every clock while out of reset
`define SHC_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication
`define SHC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

>>> rtl/core/sha_pkg.sv
// Types, constants and round functions for the SHA-256 stream hasher
package sha_pkg;
    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } out_item_t;

    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_FINISH = 1'b1;

    typedef logic [31:0] word_t;

    function automatic word_t init_chain(input logic [2:0] i);
        case (i)
            3'd0: init_chain = 32'h6a09e667;
            3'd1: init_chain = 32'hbb67ae85;
            3'd2: init_chain = 32'h3c6ef372;
            3'd3: init_chain = 32'ha54ff53a;
            3'd4: init_chain = 32'h510e527f;
            3'd5: init_chain = 32'h9b05688c;
            3'd6: init_chain = 32'h1f83d9ab;
            default: init_chain = 32'h5be0cd19;
        endcase
    endfunction

    localparam word_t ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic word_t rotr(input word_t v, input int n);
        rotr = (v >> n) | (v << (32 - n));
    endfunction
endpackage

>>> rtl/core/sha_fifo.sv
// Short queue between the front and the back of the hasher
module sha_fifo #(
    parameter int DEPTH = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  sha_pkg::in_item_t push_data,
    output logic              full,
    input  logic              pop,
    output sha_pkg::in_item_t pop_data,
    output logic              empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    sha_pkg::in_item_t mem_reg [DEPTH];
    logic [AW-1:0] wr_reg, rd_reg;
    logic [AW:0]   cnt_reg;

    assign full     = (cnt_reg == (AW+1)'(DEPTH));
    assign empty    = (cnt_reg == '0);
    assign pop_data = mem_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            mem_reg[wr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                wr_reg <= (wr_reg == AW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            end
            if (pop && !empty)
            begin
                rd_reg <= (rd_reg == AW'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (AW+1)'(push && !full) - (AW+1)'(pop && !empty);
        end
    end

    `include "sha256_stream_hasher_core_assert.svh"
    `SHC_ASSERT_NEXT(a_cnt_bound, 1'b1, cnt_reg <= (AW+1)'(DEPTH), "queue count overflow")
    `SHC_ASSERT_NEXT(a_push_full, full && !pop, full, "full queue lost its fill")
    `SHC_ASSERT_NEXT(a_pop_empty, empty && !push, empty, "empty queue gained an entry")
endmodule

>>> rtl/core/sha_engine.sv
// Back end: block gathering, padding, compression rounds and digest output
module sha_engine (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    input  sha_pkg::in_item_t  item,
    output logic               item_pop,
    output logic               out_valid,
    output sha_pkg::out_item_t out_item,
    input  logic               out_stall
);
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PAD   = 3'd1;
    localparam logic [2:0] ST_ROUND = 3'd2;
    localparam logic [2:0] ST_EMIT  = 3'd3;

    logic [2:0]  state_reg;
    logic [60:0] count_reg;
    logic [5:0]  pad_pos_reg;
    logic        pad_len_reg;   // padding block gets the length field
    logic        finish_reg;    // compression is part of a finish
    logic [5:0]  round_reg;
    logic [2:0]  emit_reg;
    sha_pkg::word_t h_reg [8];
    sha_pkg::word_t v_reg [8];
    // message bytes shift in here; the rounds then run the schedule in place
    sha_pkg::word_t w_reg [16];

    logic [5:0] pos;
    assign pos = count_reg[5:0];

    assign item_pop  = (state_reg == ST_IDLE) && item_valid;
    assign out_valid = (state_reg == ST_EMIT);
    assign out_item.digest_word = h_reg[emit_reg];
    assign out_item.word_index  = emit_reg;
    assign out_item.last_word   = (emit_reg == 3'd7);

    // round datapath
    sha_pkg::word_t w_cur, w_new, s0, s1, t1, t2, sig0, sig1, ch, maj;
    always_comb
    begin
        w_cur = w_reg[0];
        s0 = sha_pkg::rotr(w_reg[1], 7) ^ sha_pkg::rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1 = sha_pkg::rotr(w_reg[14], 17) ^ sha_pkg::rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
        w_new = s1 + w_reg[9] + s0 + w_reg[0];
        sig1 = sha_pkg::rotr(v_reg[4], 6) ^ sha_pkg::rotr(v_reg[4], 11)
             ^ sha_pkg::rotr(v_reg[4], 25);
        ch   = v_reg[6] ^ (v_reg[4] & (v_reg[5] ^ v_reg[6]));
        t1   = v_reg[7] + sig1 + ch + sha_pkg::ROUND_K[round_reg] + w_cur;
        sig0 = sha_pkg::rotr(v_reg[0], 2) ^ sha_pkg::rotr(v_reg[0], 13)
             ^ sha_pkg::rotr(v_reg[0], 22);
        maj  = (v_reg[0] & v_reg[1]) | (v_reg[2] & (v_reg[0] | v_reg[1]));
        t2   = sig0 + maj;
    end

    logic [63:0] bits;
    assign bits = {count_reg, 3'b000};

    // byte entering the block this cycle: data, the 0x80 marker, zero or length
    logic [7:0] shift_byte;
    always_comb
    begin
        if (state_reg == ST_PAD)
        begin
            if (pad_len_reg && pad_pos_reg >= 6'd56)
            begin
                shift_byte = bits[8*(7 - pad_pos_reg[2:0]) +: 8];
            end
            else
            begin
                shift_byte = 8'h00;
            end
        end
        else if (item.kind == sha_pkg::KIND_DATA)
        begin
            shift_byte = item.data_byte;
        end
        else
        begin
            shift_byte = 8'h80;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            round_reg <= '0;
            emit_reg  <= '0;
            finish_reg <= 1'b0;
            pad_len_reg <= 1'b0;
            pad_pos_reg <= '0;
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= sha_pkg::init_chain(3'(i));
                v_reg[i] <= '0;
            end
            for (int i = 0; i < 16; i++)
            begin
                w_reg[i] <= '0;
            end
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (item_valid)
                    begin
                        for (int i = 0; i < 15; i++)
                        begin
                            w_reg[i] <= {w_reg[i][23:0], w_reg[i+1][31:24]};
                        end
                        w_reg[15] <= {w_reg[15][23:0], shift_byte};
                        if (item.kind == sha_pkg::KIND_DATA)
                        begin
                            count_reg    <= count_reg + 1'b1;
                            finish_reg   <= 1'b0;
                            if (pos == 6'd63)
                            begin
                                state_reg <= ST_ROUND;
                                round_reg <= '0;
                                for (int i = 0; i < 8; i++)
                                begin
                                    v_reg[i] <= h_reg[i];
                                end
                            end
                        end
                        else
                        begin
                            // zero fill happens one byte a cycle in ST_PAD
                            finish_reg   <= 1'b1;
                            pad_pos_reg  <= pos + 1'b1;
                            pad_len_reg  <= (pos < 6'd56);
                            state_reg    <= (pos == 6'd63) ? ST_ROUND : ST_PAD;
                            round_reg    <= '0;
                            if (pos == 6'd63)
                            begin
                                for (int i = 0; i < 8; i++)
                                begin
                                    v_reg[i] <= h_reg[i];
                                end
                            end
                        end
                    end
                end
                ST_PAD:
                begin
                    // shift in zeros, or length bytes in the final block
                    for (int i = 0; i < 15; i++)
                    begin
                        w_reg[i] <= {w_reg[i][23:0], w_reg[i+1][31:24]};
                    end
                    w_reg[15] <= {w_reg[15][23:0], shift_byte};
                    pad_pos_reg <= pad_pos_reg + 1'b1;
                    if (pad_pos_reg == 6'd63)
                    begin
                        state_reg <= ST_ROUND;
                        round_reg <= '0;
                        for (int i = 0; i < 8; i++)
                        begin
                            v_reg[i] <= h_reg[i];
                        end
                    end
                end
                ST_ROUND:
                begin
                    for (int i = 0; i < 15; i++)
                    begin
                        w_reg[i] <= w_reg[i+1];
                    end
                    w_reg[15] <= w_new;
                    v_reg[7] <= v_reg[6];
                    v_reg[6] <= v_reg[5];
                    v_reg[5] <= v_reg[4];
                    v_reg[4] <= v_reg[3] + t1;
                    v_reg[3] <= v_reg[2];
                    v_reg[2] <= v_reg[1];
                    v_reg[1] <= v_reg[0];
                    v_reg[0] <= t1 + t2;
                    round_reg <= round_reg + 1'b1;
                    if (round_reg == 6'd63)
                    begin
                        h_reg[0] <= h_reg[0] + t1 + t2;
                        h_reg[1] <= h_reg[1] + v_reg[0];
                        h_reg[2] <= h_reg[2] + v_reg[1];
                        h_reg[3] <= h_reg[3] + v_reg[2];
                        h_reg[4] <= h_reg[4] + v_reg[3] + t1;
                        h_reg[5] <= h_reg[5] + v_reg[4];
                        h_reg[6] <= h_reg[6] + v_reg[5];
                        h_reg[7] <= h_reg[7] + v_reg[6];
                        if (!finish_reg)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else if (pad_len_reg)
                        begin
                            state_reg <= ST_EMIT;
                            emit_reg  <= '0;
                        end
                        else
                        begin
                            // second padding block with the length
                            state_reg   <= ST_PAD;
                            pad_len_reg <= 1'b1;
                            pad_pos_reg <= '0;
                        end
                    end
                end
                ST_EMIT:
                begin
                    if (!out_stall)
                    begin
                        emit_reg <= emit_reg + 1'b1;
                        if (emit_reg == 3'd7)
                        begin
                            state_reg <= ST_IDLE;
                            count_reg <= '0;
                            for (int i = 0; i < 8; i++)
                            begin
                                h_reg[i] <= sha_pkg::init_chain(3'(i));
                            end
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    `include "sha256_stream_hasher_core_assert.svh"
    `SHC_ASSERT_IMPL(a_pop_idle, item_pop, state_reg == ST_IDLE, "pop outside idle")
    `SHC_ASSERT_NEXT(a_emit_hold, out_valid && out_stall, out_valid && $stable(emit_reg),
        "stalled digest word moved")
    `SHC_ASSERT_NEXT(a_last_done, out_valid && !out_stall && out_item.last_word,
        state_reg == ST_IDLE && count_reg == '0, "no restart after digest")
endmodule

>>> rtl/core/sha256_stream_hasher_core.sv
// Top level: input queue in front of the SHA-256 compression engine
// Data bytes: one per cycle unless stalled; each block's 64th byte holds the engine 64 rounds.
// Finish at byte offset p < 56: zero fill and the length complete the block, rounds, then digest.
// Offsets 56 to 63 need a second block (64-byte fill with zeros and length, then 64 more rounds).
// Digest: eight words at one per cycle when not stalled; the queue holds QUEUE_DEPTH transfers.
// Reset (async, active low) loads the initial chain and clears the count.
module sha256_stream_hasher_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  sha_pkg::in_item_t  in_item,
    output logic               in_stall,
    output logic               out_valid,
    output sha_pkg::out_item_t out_item,
    input  logic               out_stall
);
    logic q_full, q_empty, q_pop;
    sha_pkg::in_item_t q_data;

    assign in_stall = q_full;

    sha_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
        .clk(clk), .rst_n(rst_n),
        .push(in_valid), .push_data(in_item), .full(q_full),
        .pop(q_pop), .pop_data(q_data), .empty(q_empty)
    );

    sha_engine u_engine (
        .clk(clk), .rst_n(rst_n),
        .item_valid(!q_empty), .item(q_data), .item_pop(q_pop),
        .out_valid(out_valid), .out_item(out_item), .out_stall(out_stall)
    );
endmodule

>>> tb/tb_sha256_stream_hasher_core.sv
// Testbench for the SHA-256 stream hasher core against a digest predictor
`timescale 1ns / 100ps

module tb_sha256_stream_hasher_core;
    localparam int IDLE_LIMIT = 20000;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    sha_pkg::in_item_t  in_item;
    logic               in_stall;
    logic               out_valid;
    sha_pkg::out_item_t out_item;
    logic               out_stall;

    sha256_stream_hasher_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_item   (in_item),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_item  (out_item),
        .out_stall (out_stall)
    );

    // predictor state
    logic [31:0] chain [8];
    logic [7:0]  msg_block [64];
    logic [60:0] msg_bytes;

    sha_pkg::in_item_t  pending_items [$];
    sha_pkg::out_item_t digest_words [$];
    int        errors = 0;
    int        idle_cycles;
    bit        hold_rx;
    int        hold_cycles;
    bit        moved;

    localparam logic [31:0] IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic logic [31:0] ror(logic [31:0] v, int n);
        return (v >> n) | (v << (32 - n));
    endfunction

    task automatic compress_block();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1, t2, s0, s1;
        for (int t = 0; t < 16; t++)
            w[t] = {msg_block[4*t], msg_block[4*t+1], msg_block[4*t+2], msg_block[4*t+3]};
        for (int t = 16; t < 64; t++)
        begin
            s0 = ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3);
            s1 = ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10);
            w[t] = s1 + w[t-7] + s0 + w[t-16];
        end
        for (int t = 0; t < 8; t++)
            v[t] = chain[t];
        for (int t = 0; t < 64; t++)
        begin
            t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
                 + (v[6] ^ (v[4] & (v[5] ^ v[6]))) + sha_pkg::ROUND_K[t] + w[t];
            t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
                 + ((v[0] & v[1]) | (v[2] & (v[0] | v[1])));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int t = 0; t < 8; t++)
            chain[t] = chain[t] + v[t];
    endtask

    task automatic predict_digest(sha_pkg::in_item_t it);
        int pos;
        logic [63:0] bit_len;
        sha_pkg::out_item_t o;
        pos = int'(msg_bytes[5:0]);
        if (it.kind == sha_pkg::KIND_DATA)
        begin
            msg_block[pos] = it.data_byte;
            msg_bytes = msg_bytes + 61'd1;
            if (pos == 63)
                compress_block();
            return;
        end
        bit_len = {msg_bytes, 3'b000};
        msg_block[pos] = 8'h80;
        for (int i = pos + 1; i < 64; i++)
            msg_block[i] = 8'h00;
        if (pos >= 56)
        begin
            compress_block();
            for (int i = 0; i < 64; i++)
                msg_block[i] = 8'h00;
        end
        for (int i = 0; i < 8; i++)
            msg_block[56+i] = bit_len[63-8*i -: 8];
        compress_block();
        for (int i = 0; i < 8; i++)
        begin
            o.digest_word = chain[i];
            o.word_index  = i[2:0];
            o.last_word   = (i == 7);
            digest_words.push_back(o);
        end
        for (int i = 0; i < 8; i++)
            chain[i] = IV[i];
        msg_bytes = '0;
    endtask

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: got %h, want %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic sha_pkg::in_item_t data_item(logic [7:0] b);
        sha_pkg::in_item_t it;
        it.kind = sha_pkg::KIND_DATA;
        it.data_byte = b;
        return it;
    endfunction

    function automatic sha_pkg::in_item_t finish_item();
        sha_pkg::in_item_t it;
        it.kind = sha_pkg::KIND_FINISH;
        it.data_byte = 8'($urandom_range(0, 255));
        return it;
    endfunction

    task automatic queue_message(int len);
        for (int i = 0; i < len; i++)
            pending_items.push_back(data_item(8'($urandom_range(0, 255))));
        pending_items.push_back(finish_item());
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // driver
    int tx_gap;
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_item  <= '0;
            tx_gap   <= 0;
        end
        else if (in_valid && in_stall)
        begin
            // hold the stalled transfer
        end
        else if (tx_gap > 0)
        begin
            in_valid <= 1'b0;
            tx_gap   <= tx_gap - 1;
        end
        else if (pending_items.size() > 0 && pending_items[0].kind === 1'bx)
        begin
            // pause marker: drain every expected word first
            in_valid <= 1'b0;
            if (digest_words.size() == 0)
                void'(pending_items.pop_front());
        end
        else if (pending_items.size() > 0)
        begin
            in_valid <= 1'b1;
            in_item  <= pending_items.pop_front();
            tx_gap   <= gap_len();
        end
        else
            in_valid <= 1'b0;
    end

    // receiver stall
    int rx_gap;
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall   <= 1'b1;
            rx_gap      <= 0;
            hold_cycles <= 0;
        end
        else if (hold_rx)
        begin
            out_stall   <= 1'b1;
            hold_cycles <= hold_cycles + 1;
        end
        else if (rx_gap > 0)
        begin
            out_stall <= 1'b1;
            rx_gap    <= rx_gap - 1;
        end
        else
        begin
            out_stall <= 1'b0;
            rx_gap    <= ($urandom_range(0, 2) == 0) ? gap_len() : 0;
        end
    end

    // monitor and checker
    sha_pkg::out_item_t want;
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            idle_cycles <= 0;
            for (int i = 0; i < 8; i++)
                chain[i] = IV[i];
            msg_bytes = '0;
        end
        else
        begin
            moved = 1'b0;
            if (in_valid && !in_stall)
            begin
                predict_digest(in_item);
                moved = 1'b1;
            end
            if (out_valid && !out_stall)
            begin
                moved = 1'b1;
                if (digest_words.size() == 0)
                begin
                    report("unexpected word", out_item.digest_word, 32'h0);
                end
                else
                begin
                    want = digest_words.pop_front();
                    if (out_item.digest_word !== want.digest_word)
                        report("digest_word", out_item.digest_word, want.digest_word);
                    if (out_item.word_index !== want.word_index)
                        report("word_index", 32'(out_item.word_index),
                               32'(want.word_index));
                    if (out_item.last_word !== want.last_word)
                        report("last_word", 32'(out_item.last_word), 32'(want.last_word));
                end
            end
            idle_cycles <= moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    sha_pkg::in_item_t pause_mark;
    initial
    begin
        int hold_len;
        rst_n = 1'b0;
        hold_rx = 0;
        pause_mark.kind = 1'bx;
        pause_mark.data_byte = '0;

        // directed: empty message, "abc", finish at the last byte offset,
        // then a full block followed by a finish that needs a second block
        pending_items.push_back(finish_item());
        pending_items.push_back(data_item(8'h61));
        pending_items.push_back(data_item(8'h62));
        pending_items.push_back(data_item(8'h63));
        pending_items.push_back(finish_item());
        queue_message(63);
        pending_items.push_back(pause_mark);
        queue_message(120);

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // long receiver hold on the first digest while the sender keeps offering
        wait (out_valid === 1'b1);
        @(negedge clk);
        hold_rx = 1;
        hold_len = 400;
        wait (hold_cycles >= hold_len);
        @(negedge clk);
        hold_rx = 0;

        wait (pending_items.size() == 0 && !in_valid);
        @(posedge clk);
        wait (digest_words.size() == 0);
        repeat (20) @(posedge clk);
        if (errors == 0 && digest_words.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/sha_pkg.sv
rtl/core/sha_fifo.sv
rtl/core/sha_engine.sv
rtl/core/sha256_stream_hasher_core.sv
tb/tb_sha256_stream_hasher_core.sv
